>>> design/pxb_pkg.sv
`default_nettype none
package pxb_pkg;

    // channel and register widths
    localparam int CHAN_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    // fixed-point scale: channel value c stands for c/255
    localparam logic [7:0]  FULL_SCALE = 8'd255;
    localparam logic [15:0] FULL_SQ    = 16'd65025;
    localparam logic [23:0] FULL_SQ_X2 = 24'd130050;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OPACITY = 2'd1;

    // reset value of the opacity register
    localparam logic [7:0] OPACITY_RST = 8'd255;

    typedef enum logic [2:0] {
        MODE_NORMAL   = 3'd0,
        MODE_MULTIPLY = 3'd1,
        MODE_SCREEN   = 3'd2,
        MODE_OVERLAY  = 3'd3,
        MODE_ADD      = 3'd4
    } t_blend_mode;

    typedef struct packed {
        logic [7:0] base_red;
        logic [7:0] base_green;
        logic [7:0] base_blue;
        logic [7:0] base_alpha;
        logic [7:0] over_red;
        logic [7:0] over_green;
        logic [7:0] over_blue;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } t_pix_out;

endpackage
`default_nettype wire

>>> design/pixel_blend_with_opacity.sv
// pixel blend with opacity
//
// i_start with i_pixel carries one base pixel (rgba) and one overlay pixel (rgb).
// A transaction is taken at every rising edge where i_start is high and o_busy
// low; o_busy never rises, so a pixel may enter on every clock.
// Each colour channel is blended by the configured mode (normal, multiply,
// screen, overlay, add), mixed with the base channel by opacity and truncated;
// base alpha is carried through untouched.
// Results appear on o_result for one cycle with o_done high, registered in the
// six-stage pipeline (products, blend select, mix products, sum, quotient
// estimate, quotient correction); throughput is one pixel per clock.
// The receiver cannot stall the output.
// Configuration goes through i_cfg_valid/o_cfg_ready with i_cfg_index and
// i_cfg_data: index 0 is the blend mode, index 1 the opacity; other indexes
// are ignored. Writes must be made by the user while no pixel is in flight; the
// block does not enforce this. Synchronous active-low reset empties the pipeline
// and sets mode normal, opacity 255.
`default_nettype none
module pixel_blend_with_opacity (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    output logic                              o_busy,
    input  wire pxb_pkg::t_pix_in             i_pixel,
    output logic                              o_done,
    output pxb_pkg::t_pix_out                 o_result,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [pxb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [pxb_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    localparam int NCH    = 3;
    localparam int STAGES = 6;

    // configuration registers
    pxb_pkg::t_blend_mode r_mode;
    logic [7:0]           r_opacity;

    // pipeline valid bits and alpha carry
    logic [STAGES-1:0] r_vld;
    logic [7:0]        r_alpha [STAGES];

    // stage 1: channels and raw products
    logic [7:0]  r1_b  [NCH];
    logic [7:0]  r1_o  [NCH];
    logic [15:0] r1_p  [NCH];
    logic [15:0] r1_q  [NCH];
    logic [8:0]  r1_s  [NCH];
    // stage 2: blended value and base weight product
    logic [15:0] r2_r  [NCH];
    logic [15:0] r2_ma [NCH];
    // stage 3: the two mix terms
    logic [23:0] r3_n1 [NCH];
    logic [23:0] r3_n2 [NCH];
    // stage 4: numerator
    logic [23:0] r4_n  [NCH];
    // stage 5: numerator and quotient estimate product
    logic [23:0] r5_n  [NCH];
    logic [23:0] r5_pr [NCH];
    // stage 6: output register
    pxb_pkg::t_pix_out r_result;
    logic              r_done;

    // next values
    logic [7:0]  n_b  [NCH];
    logic [7:0]  n_o  [NCH];
    logic [15:0] n_r  [NCH];
    logic [15:0] n_ma [NCH];
    logic [23:0] n_n1 [NCH];
    logic [23:0] n_n2 [NCH];
    logic [23:0] n_pr [NCH];
    logic [23:0] n_rem [NCH];
    logic [7:0]  n_q  [NCH];
    logic        w_take;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_take      = i_start && !o_busy;
    assign o_done      = r_done;
    assign o_result    = r_result;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= pxb_pkg::MODE_NORMAL;
            r_opacity <= pxb_pkg::OPACITY_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pxb_pkg::CFG_IDX_MODE:    r_mode    <= pxb_pkg::t_blend_mode'(i_cfg_data[2:0]);
                pxb_pkg::CFG_IDX_OPACITY: r_opacity <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[STAGES-2:0], w_take};
            r_done <= r_vld[STAGES-2];
        end
    end

    // channel lanes from the input transaction
    always_comb begin
        n_b[0] = i_pixel.base_red;
        n_b[1] = i_pixel.base_green;
        n_b[2] = i_pixel.base_blue;
        n_o[0] = i_pixel.over_red;
        n_o[1] = i_pixel.over_green;
        n_o[2] = i_pixel.over_blue;
    end

    // blend select per mode, with base weight product
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            n_ma[c] = 16'(r1_b[c]) * 16'(pxb_pkg::FULL_SCALE - r_opacity);
            case (r_mode)
                pxb_pkg::MODE_MULTIPLY: n_r[c] = r1_p[c];
                pxb_pkg::MODE_SCREEN:   n_r[c] = pxb_pkg::FULL_SQ - r1_q[c];
                pxb_pkg::MODE_OVERLAY: begin
                    if (!r1_b[c][7])
                        n_r[c] = {r1_p[c][14:0], 1'b0};
                    else
                        n_r[c] = pxb_pkg::FULL_SQ - {r1_q[c][14:0], 1'b0};
                end
                pxb_pkg::MODE_ADD: begin
                    if (r1_s[c][8])
                        n_r[c] = pxb_pkg::FULL_SQ;
                    else
                        n_r[c] = {r1_s[c][7:0], 8'd0} - {8'd0, r1_s[c][7:0]};
                end
                default: n_r[c] = {r1_o[c], 8'd0} - {8'd0, r1_o[c]};
            endcase
        end
    end

    // mix terms: 255*b*(255-a) and R*a
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            n_n1[c] = {r2_ma[c], 8'd0} - {8'd0, r2_ma[c]};
            n_n2[c] = 24'(r2_r[c]) * 24'(r_opacity);
        end
    end

    // quotient estimate n/65536 never exceeds the true quotient by division
    // by 65025, and falls short of it by at most two
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            n_pr[c]  = 24'(r4_n[c][23:16]) * 24'(pxb_pkg::FULL_SQ);
            n_rem[c] = r5_n[c] - r5_pr[c];
            n_q[c]   = r5_n[c][23:16]
                     + 8'(n_rem[c] >= 24'(pxb_pkg::FULL_SQ))
                     + 8'(n_rem[c] >= pxb_pkg::FULL_SQ_X2);
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NCH; c++) begin
            r1_b[c]  <= n_b[c];
            r1_o[c]  <= n_o[c];
            r1_p[c]  <= 16'(n_b[c]) * 16'(n_o[c]);
            r1_q[c]  <= 16'(pxb_pkg::FULL_SCALE - n_b[c]) * 16'(pxb_pkg::FULL_SCALE - n_o[c]);
            r1_s[c]  <= {1'b0, n_b[c]} + {1'b0, n_o[c]};
            r2_r[c]  <= n_r[c];
            r2_ma[c] <= n_ma[c];
            r3_n1[c] <= n_n1[c];
            r3_n2[c] <= n_n2[c];
            r4_n[c]  <= r3_n1[c] + r3_n2[c];
            r5_n[c]  <= r4_n[c];
            r5_pr[c] <= n_pr[c];
        end
        r_alpha[0] <= i_pixel.base_alpha;
        for (int s = 1; s < STAGES; s++) begin
            r_alpha[s] <= r_alpha[s-1];
        end
        r_result.out_red   <= n_q[0];
        r_result.out_green <= n_q[1];
        r_result.out_blue  <= n_q[2];
        r_result.out_alpha <= r_alpha[STAGES-2];
    end

endmodule
`default_nettype wire

>>> design/pxb_checker.sv
`default_nettype none
module pxb_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_start,
    input wire logic              o_busy,
    input wire pxb_pkg::t_pix_in  i_pixel,
    input wire logic              o_done,
    input wire pxb_pkg::t_pix_out o_result
);

    // every taken transaction gives a result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##6 o_done)
        else $error("result missing six cycles after a transaction");

    // no result without a matching earlier transaction
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, 6))
        else $error("result without a matching transaction");

    // alpha is carried through unchanged
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.out_alpha == $past(i_pixel.base_alpha, 6)))
        else $error("alpha does not match base alpha");

endmodule

bind pixel_blend_with_opacity pxb_checker u_pxb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .i_pixel  (i_pixel),
    .o_done   (o_done),
    .o_result (o_result)
);
`default_nettype wire

>>> bench/pixel_blend_with_opacity_tb.sv
`timescale 1ns / 100ps
module pixel_blend_with_opacity_tb;

    // scale constants for the blend arithmetic
    localparam int unsigned SCALE    = 32'(pxb_pkg::FULL_SCALE);
    localparam int unsigned SCALE_SQ = 32'(pxb_pkg::FULL_SQ);

    // indexes with no register behind them
    localparam logic [pxb_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
    localparam logic [pxb_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;

    // undefined blend modes, expected to act as normal
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam int RANDOM_PIXELS = 1300;
    localparam int DRAIN_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 150000;

    typedef enum logic {
        ROW_PIX,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind                         kind;
        logic [pxb_pkg::CFG_IDX_W-1:0]     idx;
        logic [pxb_pkg::CFG_DAT_W-1:0]     dat;
        pxb_pkg::t_pix_in                  pix;
        logic                              typed;
        pxb_pkg::t_pix_out                 want;
    } t_dir_row;

    localparam int DIR_ROWS = 32;

    // directed stimulus: register writes and pixels, typed results where obvious
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // reset settings: normal mode, full opacity gives the overlay pixel
        '{ROW_PIX, pxb_pkg::CFG_IDX_MODE, 8'h00, 56'h00_00_00_00_FF_FF_FF, 1'b1,
          32'hFF_FF_FF_00},
        '{ROW_PIX, pxb_pkg::CFG_IDX_MODE, 8'h00, 56'hFF_FF_FF_FF_00_00_00, 1'b1,
          32'h00_00_00_FF},
        '{ROW_PIX, pxb_pkg::CFG_IDX_MODE, 8'h00, 56'h5A_A5_3C_C3_96_69_0F, 1'b1,
          32'h96_69_0F_C3},
        // zero opacity gives the base pixel
        '{ROW_CFG, pxb_pkg::CFG_IDX_OPACITY, 8'h00, 56'h0, 1'b0, 32'h0},
        '{ROW_PIX, pxb_pkg::CFG_IDX_MODE, 8'h00, 56'h12_34_56_78_FF_00_AB, 1'b1,
          32'h12_34_56_78},
        '{ROW_CFG, pxb_pkg::CFG_IDX_OPACITY, 8'hFF, 56'h0, 1'b0, 32'h0},
        // multiply
        '{ROW_CFG, pxb_pkg::CFG_IDX_MODE, 8'(pxb_pkg::MODE_MULTIPLY), 56'h0, 1'b0, 32'h0},
        '{ROW_PIX, pxb_pkg::CFG_IDX_MODE, 8'h00, 56'hFF_FF_FF_80_80_01_FE, 1'b1,
          32'h80_01_FE_80},
        '{ROW_PIX, pxb_pkg::CFG_IDX_MODE, 8'h00, 56'h00_7F_80_01_FF_FF_FF, 1'b1,
          32'h00_7F_80_01},
        '{ROW_PIX, pxb_pkg::CFG_IDX_MODE, 8'h00, 56'h9C_47_E1_2B_5D_C8_33, 1'b0, 32'h0},
        // screen
        '{ROW_CFG, pxb_pkg::CFG_IDX_MODE, 8'(pxb_pkg::MODE_SCREEN), 56'h0, 1'b0, 32'h0},
        '{ROW_PIX, pxb_pkg::CFG_IDX_MODE, 8'h00, 56'h00_FF_80_00_00_00_80, 1'b0, 32'h0},
        '{ROW_PIX, pxb_pkg::CFG_IDX_MODE, 8'h00, 56'h3E_C1_7F_E7_A4_FF_01, 1'b0, 32'h0},
        // overlay either side of the mid threshold
        '{ROW_CFG, pxb_pkg::CFG_IDX_MODE, 8'(pxb_pkg::MODE_OVERLAY), 56'h0, 1'b0, 32'h0},
        '{ROW_PIX, pxb_pkg::CFG_IDX_MODE, 8'h00, 56'h7F_80_00_40_FF_FF_FF, 1'b0, 32'h0},
        '{ROW_PIX, pxb_pkg::CFG_IDX_MODE, 8'h00, 56'h7F_80_FF_BF_00_00_80, 1'b0, 32'h0},
        '{ROW_CFG, pxb_pkg::CFG_IDX_OPACITY, 8'h80, 56'h0, 1'b0, 32'h0},
        '{ROW_PIX, pxb_pkg::CFG_IDX_MODE, 8'h00, 56'h7F_80_C0_55_A0_30_FF, 1'b0, 32'h0},
        // add, with and without saturation
        '{ROW_CFG, pxb_pkg::CFG_IDX_MODE, 8'(pxb_pkg::MODE_ADD), 56'h0, 1'b0, 32'h0},
        '{ROW_CFG, pxb_pkg::CFG_IDX_OPACITY, 8'hFF, 56'h0, 1'b0, 32'h0},
        '{ROW_PIX, pxb_pkg::CFG_IDX_MODE, 8'h00, 56'hC8_10_FF_00_C8_20_FF, 1'b1,
          32'hFF_30_FF_00},
        '{ROW_PIX, pxb_pkg::CFG_IDX_MODE, 8'h00, 56'h00_00_01_FF_00_FF_FE, 1'b1,
          32'h00_FF_FF_FF},
        '{ROW_CFG, pxb_pkg::CFG_IDX_OPACITY, 8'h01, 56'h0, 1'b0, 32'h0},
        '{ROW_PIX, pxb_pkg::CFG_IDX_MODE, 8'h00, 56'hFE_01_80_AA_FF_FE_7F, 1'b0, 32'h0},
        // undefined modes, with upper data bits set or clear, act as normal
        '{ROW_CFG, pxb_pkg::CFG_IDX_MODE, {5'b11111, MODE_SPARE_LO}, 56'h0, 1'b0, 32'h0},
        '{ROW_CFG, pxb_pkg::CFG_IDX_OPACITY, 8'hFF, 56'h0, 1'b0, 32'h0},
        '{ROW_PIX, pxb_pkg::CFG_IDX_MODE, 8'h00, 56'h11_22_33_44_AA_BB_CC, 1'b1,
          32'hAA_BB_CC_44},
        '{ROW_CFG, pxb_pkg::CFG_IDX_MODE, {5'b00000, MODE_SPARE_HI}, 56'h0, 1'b0, 32'h0},
        '{ROW_PIX, pxb_pkg::CFG_IDX_MODE, 8'h00, 56'h80_7F_01_FE_55_AA_00, 1'b0, 32'h0},
        // writes to unused indexes must change nothing
        '{ROW_CFG, CFG_IDX_SPARE2, 8'h00, 56'h0, 1'b0, 32'h0},
        '{ROW_CFG, CFG_IDX_SPARE3, 8'h00, 56'h0, 1'b0, 32'h0},
        '{ROW_PIX, pxb_pkg::CFG_IDX_MODE, 8'h00, 56'h6B_B6_2D_D2_93_39_C6, 1'b0, 32'h0}
    };

    // edge values picked often for the channels
    localparam logic [7:0] EDGE_VALS [6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_start = 1'b0;
    pxb_pkg::t_pix_in                  i_pixel = '0;
    logic                              i_cfg_valid = 1'b0;
    logic [pxb_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [pxb_pkg::CFG_DAT_W-1:0]     i_cfg_data = '0;
    logic                              o_busy;
    logic                              o_done;
    pxb_pkg::t_pix_out                 o_result;
    logic                              o_cfg_ready;

    // testbench copy of the block's registers
    logic [2:0]             mode_reg = pxb_pkg::MODE_NORMAL;
    logic [7:0]             opacity_reg = pxb_pkg::OPACITY_RST;

    pxb_pkg::t_pix_out      blended_due [$];
    int                     err_cnt = 0;
    int                     cycle_cnt = 0;

    pixel_blend_with_opacity u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_pixel     (i_pixel),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // one colour channel: blend by mode, mix with base by opacity, truncate
    function automatic logic [7:0] blend_chan(logic [7:0] base, logic [7:0] over);
        int unsigned b;
        int unsigned o;
        int unsigned a;
        int unsigned r;
        int unsigned n;
        b = 32'(base);
        o = 32'(over);
        a = 32'(opacity_reg);
        case (mode_reg)
            pxb_pkg::MODE_MULTIPLY: r = b * o;
            pxb_pkg::MODE_SCREEN:   r = SCALE_SQ - (SCALE - b) * (SCALE - o);
            pxb_pkg::MODE_OVERLAY:  r = (b < 128) ? 2 * b * o
                                                  : SCALE_SQ - 2 * (SCALE - b) * (SCALE - o);
            pxb_pkg::MODE_ADD:      r = SCALE * ((b + o > SCALE) ? SCALE : b + o);
            default:                r = SCALE * o;
        endcase
        n = SCALE * b * (SCALE - a) + r * a;
        return 8'(n / SCALE_SQ);
    endfunction

    function automatic pxb_pkg::t_pix_out blend_pixel(pxb_pkg::t_pix_in pix);
        pxb_pkg::t_pix_out res;
        res.out_red   = blend_chan(pix.base_red,   pix.over_red);
        res.out_green = blend_chan(pix.base_green, pix.over_green);
        res.out_blue  = blend_chan(pix.base_blue,  pix.over_blue);
        res.out_alpha = pix.base_alpha;
        return res;
    endfunction

    function automatic logic [7:0] pick_chan();
        if ($urandom_range(0, 3) == 0)
            return EDGE_VALS[$urandom_range(0, 5)];
        return 8'($urandom);
    endfunction

    // register write, only once every outstanding pixel has come out;
    // valid is dropped again by the next pixel transaction
    task automatic write_reg(logic [pxb_pkg::CFG_IDX_W-1:0] idx,
                             logic [pxb_pkg::CFG_DAT_W-1:0] dat);
        i_start <= 1'b0;
        while (blended_due.size() != 0)
            @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= dat;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == pxb_pkg::CFG_IDX_MODE)
            mode_reg = dat[2:0];
        else if (idx == pxb_pkg::CFG_IDX_OPACITY)
            opacity_reg = dat;
    endtask

    // one pixel transaction after an idle gap; start stays high when gap is zero
    task automatic send_pixel(pxb_pkg::t_pix_in pix, logic typed, pxb_pkg::t_pix_out want,
                              int gap);
        i_cfg_valid <= 1'b0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_pixel <= pix;
        do @(posedge i_clk); while (o_busy);
        blended_due.push_back(typed ? want : blend_pixel(pix));
    endtask

    task automatic check_chan(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        pxb_pkg::t_pix_out want;
        if (i_rst_n && o_done) begin
            if (blended_due.size() == 0) begin
                $error("unexpected result %h with nothing outstanding", o_result);
                err_cnt++;
            end else begin
                want = blended_due.pop_front();
                check_chan("out_red",   want.out_red,   o_result.out_red);
                check_chan("out_green", want.out_green, o_result.out_green);
                check_chan("out_blue",  want.out_blue,  o_result.out_blue);
                check_chan("out_alpha", want.out_alpha, o_result.out_alpha);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("pixel_blend_with_opacity_tb: done, errors");
            $finish;
        end
    end

    // stimulus
    initial begin
        pxb_pkg::t_pix_in pix;
        int      sent;
        int      phase_len;
        bit      no_idle;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIR_TABLE[i].kind == ROW_CFG)
                write_reg(DIR_TABLE[i].idx, DIR_TABLE[i].dat);
            else
                send_pixel(DIR_TABLE[i].pix, DIR_TABLE[i].typed, DIR_TABLE[i].want,
                           $urandom_range(0, 9));
        end

        // random phases, each with its own register settings
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            write_reg(pxb_pkg::CFG_IDX_MODE, {5'($urandom), 3'($urandom_range(0, 7))});
            case ($urandom_range(0, 4))
                0:       write_reg(pxb_pkg::CFG_IDX_OPACITY, 8'd0);
                1:       write_reg(pxb_pkg::CFG_IDX_OPACITY, 8'd255);
                2:       write_reg(pxb_pkg::CFG_IDX_OPACITY, EDGE_VALS[$urandom_range(0, 5)]);
                default: write_reg(pxb_pkg::CFG_IDX_OPACITY, 8'($urandom));
            endcase
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE2 : CFG_IDX_SPARE3,
                          8'($urandom));
            phase_len = $urandom_range(40, 160);
            no_idle = ($urandom_range(0, 2) == 0);
            for (int k = 0; k < phase_len; k++) begin
                pix.base_red   = pick_chan();
                pix.base_green = pick_chan();
                pix.base_blue  = pick_chan();
                pix.base_alpha = pick_chan();
                pix.over_red   = pick_chan();
                pix.over_green = pick_chan();
                pix.over_blue  = pick_chan();
                send_pixel(pix, 1'b0, '0, no_idle ? 0 : $urandom_range(0, 9));
            end
            sent += phase_len;
        end

        // drain and report
        i_start <= 1'b0;
        while (blended_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("pixel_blend_with_opacity_tb: done, clean");
        else
            $display("pixel_blend_with_opacity_tb: done, errors");
        $finish;
    end

endmodule
